### sv/npc_pkg.sv
// Shared types and constants of the nearest palette color search block.
`default_nettype none
package npc_pkg;

   localparam int COMP_W = 8;
   localparam int RGB_W  = 3 * COMP_W;
   localparam int SQ_W   = 2 * COMP_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int OUT_W  = 8;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } npc_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } npc_state_type;

   typedef struct packed {
      logic red_valid;
      logic first;
   } npc_tag_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } npc_rgb_type;

endpackage
`default_nettype wire

### sv/npc_dist.sv
// Squared RGB distance unit: absolute differences and squares, then the sum.
`default_nettype none
module npc_dist
   import npc_pkg::*;
(
   input  wire logic              clock,
   input  npc_rgb_type            color,
   input  npc_rgb_type            entry,
   output logic [DIST_W-1:0]      sq_dist
);

   logic [COMP_W-1:0] diff_r, diff_g, diff_b;
   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SQ_W-1:0]   sq_r_in, sq_g_in, sq_b_in;
   logic [DIST_W-1:0] dist_ff, dist_in;

   always_comb begin
      diff_r  = (color.red >= entry.red) ? color.red - entry.red : entry.red - color.red;
      diff_g  = (color.green >= entry.green) ? color.green - entry.green
                                             : entry.green - color.green;
      diff_b  = (color.blue >= entry.blue) ? color.blue - entry.blue
                                           : entry.blue - color.blue;
      sq_r_in = SQ_W'(diff_r) * SQ_W'(diff_r);
      sq_g_in = SQ_W'(diff_g) * SQ_W'(diff_g);
      sq_b_in = SQ_W'(diff_b) * SQ_W'(diff_b);
      dist_in = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
   end

   always_ff @(posedge clock) begin
      sq_r_ff <= sq_r_in;
      sq_g_ff <= sq_g_in;
      sq_b_ff <= sq_b_in;
      dist_ff <= dist_in;
   end

   assign sq_dist = dist_ff;

endmodule
`default_nettype wire

### sv/npc_best.sv
// Running minimum of the distance and the index that holds it.
`default_nettype none
module npc_best
   import npc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
)
(
   input  wire logic                               clock,
   input  npc_tag_type                              tag,
   input  wire logic [$clog2(PALETTE_ENTRIES)-1:0]  idx,
   input  wire logic [DIST_W-1:0]                   sq_dist,
   output logic [$clog2(PALETTE_ENTRIES)-1:0]       best_idx
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;

   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (tag.red_valid && (tag.first || sq_dist < best_dist_ff)) begin
         best_dist_in = sq_dist;
         best_idx_in  = idx;
      end
   end

   always_ff @(posedge clock) begin
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   assign best_idx = best_idx_ff;

endmodule
`default_nettype wire

### sv/npc_ctrl.sv
// Scan sequencer: walks the palette addresses and tags the distance pipeline.
`default_nettype none
module npc_ctrl
   import npc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
)
(
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               query_start,
   output logic                                    busy,
   output logic [$clog2(PALETTE_ENTRIES)-1:0]      rd_addr,
   output npc_tag_type                             cmp_tag,
   output logic [$clog2(PALETTE_ENTRIES)-1:0]      cmp_idx,
   output logic                                    done
);

   localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
   localparam int STAGES = 3;

   npc_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   npc_tag_type       tag_ff [STAGES];
   logic [IDX_W-1:0]  idx_ff [STAGES];
   npc_tag_type       tag_in;
   logic              pipe_busy;
   logic              done_ff, done_in;
   logic              last_addr;

   assign last_addr = (cnt_ff == IDX_W'(PALETTE_ENTRIES - 1));
   assign pipe_busy = tag_ff[0].red_valid | tag_ff[1].red_valid | tag_ff[2].red_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_addr) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in           = cnt_ff;
      tag_in.red_valid = 1'b0;
      tag_in.first     = 1'b0;
      done_in          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
         end
         ST_SCAN: begin
            tag_in.red_valid = 1'b1;
            tag_in.first     = (cnt_ff == '0);
            cnt_in           = cnt_ff + 1'b1;
         end
         ST_DRAIN: begin
            done_in = !pipe_busy;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
         for (int s = 0; s < STAGES; s++) begin
            tag_ff[s] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         done_ff   <= done_in;
         tag_ff[0] <= tag_in;
         for (int s = 1; s < STAGES; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff[0] <= cnt_ff;
      for (int s = 1; s < STAGES; s++) begin
         idx_ff[s] <= idx_ff[s-1];
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rd_addr = cnt_ff;
   assign cmp_tag = tag_ff[STAGES-1];
   assign cmp_idx = idx_ff[STAGES-1];
   assign done    = done_ff;

endmodule
`default_nettype wire

### sv/nearest_palette_color_search.sv
// Top level of the nearest palette color search: palette memory and datapath.
// Usage:
// An item is accepted at a rising clock edge where start is high and busy is
// low. With req_op at load, the item writes req_red, req_green and req_blue to
// palette entry req_entry_index (ignored when that index is outside the
// palette); it gives no result and busy stays low, so loads go one per cycle.
// With req_op at query, busy rises and the block scans the palette one entry
// per cycle through a single read port and one shared squared-distance unit.
// The result, the lowest index of minimal squared RGB distance, appears on
// rsp_nearest_index with rsp_valid high for exactly one cycle, once the scan
// has passed the three-stage read and distance pipeline, the running-minimum
// register and the done register; busy falls in that same cycle, and no new
// item is accepted before busy falls. The receiver cannot stall. Reset
// returns the sequencer to idle; the palette content is undefined until
// loaded, and a query must only meet loaded entries.
`default_nettype none
module nearest_palette_color_search
   import npc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_op,
   input  wire logic [7:0]        req_entry_index,
   input  wire logic [COMP_W-1:0] req_red,
   input  wire logic [COMP_W-1:0] req_green,
   input  wire logic [COMP_W-1:0] req_blue,
   output logic                   rsp_valid,
   output logic [OUT_W-1:0]       rsp_nearest_index
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   logic              accept;
   logic              load_en;
   logic              query_start;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [RGB_W-1:0]  palette_mem [PALETTE_ENTRIES];
   logic [RGB_W-1:0]  rdata_ff;
   npc_rgb_type       color_ff, color_in;
   npc_rgb_type       entry;
   npc_tag_type       cmp_tag;
   logic [IDX_W-1:0]  cmp_idx;
   logic [DIST_W-1:0] sq_dist;
   logic [IDX_W-1:0]  best_idx;

   assign accept      = start && !busy;
   assign load_en     = accept && (npc_op_type'(req_op) == OP_LOAD) &&
                        (32'(req_entry_index) < 32'(PALETTE_ENTRIES));
   assign query_start = accept && (npc_op_type'(req_op) == OP_QUERY);
   assign wr_addr     = IDX_W'(req_entry_index);

   always_comb begin
      color_in = color_ff;
      if (query_start) begin
         color_in.red   = req_red;
         color_in.green = req_green;
         color_in.blue  = req_blue;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         palette_mem[wr_addr] <= {req_red, req_green, req_blue};
      end
      rdata_ff <= palette_mem[rd_addr];
   end

   assign entry = npc_rgb_type'(rdata_ff);

   npc_ctrl #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .query_start(query_start),
      .busy       (busy),
      .rd_addr    (rd_addr),
      .cmp_tag    (cmp_tag),
      .cmp_idx    (cmp_idx),
      .done       (rsp_valid)
   );

   npc_dist u_dist (
      .clock  (clock),
      .color  (color_ff),
      .entry  (entry),
      .sq_dist(sq_dist)
   );

   npc_best #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_best (
      .clock   (clock),
      .tag     (cmp_tag),
      .idx     (cmp_idx),
      .sq_dist (sq_dist),
      .best_idx(best_idx)
   );

   assign rsp_nearest_index = OUT_W'(best_idx);

endmodule
`default_nettype wire
